/* sv/stlg_pkg.sv */
// ----------------------------------------------------------------------------
// stlg_pkg
// Shared types, constants and the CRC step of the scan telegram receiver.
// ----------------------------------------------------------------------------
package stlg_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 820;
  localparam int unsigned CMD_QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0]  START_BYTE    = 8'h02;
  localparam logic [7:0]  TELEGRAM_CODE = 8'hB0;
  localparam logic [15:0] CRC_POLY      = 16'h8005;

  localparam logic KIND_RANGE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CRC      = 2'd1;
  localparam logic [1:0] ST_CODE     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [1:0]  UNIT_CM      = 2'd0;
  localparam logic [16:0] MAX_RANGE_CM = 17'd80000;
  localparam logic [16:0] MAX_RANGE_MM = 17'd36000;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  // one unit of work for the back end
  typedef struct packed {
    logic        kind;
    logic [15:0] word;
    logic [9:0]  index;
    logic [1:0]  status;
    logic [15:0] format;
  } cmd_t;

  // scanner CRC: shift, fold in polynomial on carry, xor previous and new byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                           input logic [7:0]  prev,
                                           input logic [7:0]  data);
    logic [15:0] c;
    begin
      c = {crc[14:0], 1'b0};
      if (crc[15]) begin
        c = c ^ CRC_POLY;
      end
      crc_step = c ^ {prev, data};
    end
  endfunction

endpackage

/* sv/stlg_front.sv */
// ----------------------------------------------------------------------------
// stlg_front
// Byte parser: frame sync, length, CRC, format word; issues commands.
// ----------------------------------------------------------------------------
module stlg_front #(
  parameter int unsigned MAX_FRAME_BYTES = stlg_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      rx_byte,
  output logic            cmd_valid,
  output stlg_pkg::cmd_t  cmd
);

  localparam logic [16:0] MAX_LEN = 17'(MAX_FRAME_BYTES);

  stlg_pkg::phase_t phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] crc_accumulator, crc_accumulator_next;
  logic [7:0]  previous_byte, previous_byte_next;
  logic [15:0] format_word, format_word_next;
  logic [9:0]  measure_index, measure_index_next;
  logic [1:0]  frame_error, frame_error_next;

  logic [15:0] crc_fed;
  logic [15:0] len_full;
  logic        too_long;
  logic        data_last;
  logic [9:0]  count_new;
  logic [11:0] need_bytes;

  assign crc_fed    = stlg_pkg::crc_step(crc_accumulator, previous_byte, rx_byte);
  assign len_full   = {rx_byte, payload_length[7:0]};
  assign too_long   = (17'(len_full) + 17'd6) > MAX_LEN;
  assign data_last  = (17'(byte_position) + 17'd1) >= 17'(payload_length);
  assign count_new  = {rx_byte[1:0], format_word[7:0]};
  assign need_bytes = {1'b0, count_new, 1'b0} + 12'd3;

  // next state
  always_comb begin
    phase_next = phase;
    if (in_valid) begin
      case (phase)
        stlg_pkg::PH_HUNT: begin
          if (rx_byte == stlg_pkg::START_BYTE) begin
            phase_next = stlg_pkg::PH_ADDR;
          end
        end
        stlg_pkg::PH_ADDR:   phase_next = stlg_pkg::PH_LEN_LO;
        stlg_pkg::PH_LEN_LO: phase_next = stlg_pkg::PH_LEN_HI;
        stlg_pkg::PH_LEN_HI: begin
          if (too_long) begin
            phase_next = stlg_pkg::PH_HUNT;
          end else if (len_full == 16'd0) begin
            phase_next = stlg_pkg::PH_CRC_LO;
          end else begin
            phase_next = stlg_pkg::PH_DATA;
          end
        end
        stlg_pkg::PH_DATA: begin
          if (data_last) begin
            phase_next = stlg_pkg::PH_CRC_LO;
          end
        end
        stlg_pkg::PH_CRC_LO: phase_next = stlg_pkg::PH_CRC_HI;
        stlg_pkg::PH_CRC_HI: phase_next = stlg_pkg::PH_HUNT;
        default:             phase_next = stlg_pkg::PH_HUNT;
      endcase
    end
  end

  // datapath and command outputs
  always_comb begin
    byte_position_next   = byte_position;
    payload_length_next  = payload_length;
    crc_accumulator_next = crc_accumulator;
    previous_byte_next   = previous_byte;
    format_word_next     = format_word;
    measure_index_next   = measure_index;
    frame_error_next     = frame_error;
    cmd_valid            = 1'b0;
    cmd.kind             = stlg_pkg::KIND_RANGE;
    cmd.word             = {rx_byte, previous_byte};
    cmd.index            = measure_index;
    cmd.status           = stlg_pkg::ST_OK;
    cmd.format           = format_word;
    if (in_valid) begin
      case (phase)
        stlg_pkg::PH_HUNT: begin
          if (rx_byte == stlg_pkg::START_BYTE) begin
            crc_accumulator_next = stlg_pkg::crc_step(16'd0, 8'd0, rx_byte);
            previous_byte_next   = rx_byte;
            format_word_next     = 16'd0;
            measure_index_next   = 10'd0;
            frame_error_next     = stlg_pkg::ST_OK;
            byte_position_next   = 16'd0;
            payload_length_next  = 16'd0;
          end
        end
        stlg_pkg::PH_ADDR: begin
          crc_accumulator_next = crc_fed;
          previous_byte_next   = rx_byte;
        end
        stlg_pkg::PH_LEN_LO: begin
          crc_accumulator_next = crc_fed;
          previous_byte_next   = rx_byte;
          payload_length_next  = {8'd0, rx_byte};
        end
        stlg_pkg::PH_LEN_HI: begin
          crc_accumulator_next = crc_fed;
          previous_byte_next   = rx_byte;
          payload_length_next  = len_full;
          if (too_long) begin
            cmd_valid  = 1'b1;
            cmd.kind   = stlg_pkg::KIND_STATUS;
            cmd.index  = 10'd0;
            cmd.status = stlg_pkg::ST_OVERFLOW;
          end else if (len_full == 16'd0) begin
            frame_error_next = stlg_pkg::ST_CODE;
          end else begin
            byte_position_next = 16'd0;
          end
        end
        stlg_pkg::PH_DATA: begin
          if (byte_position == 16'd0) begin
            if (rx_byte != stlg_pkg::TELEGRAM_CODE) begin
              frame_error_next = stlg_pkg::ST_CODE;
            end else if (payload_length < 16'd3) begin
              frame_error_next = stlg_pkg::ST_OVERFLOW;
            end
          end else if (frame_error == stlg_pkg::ST_OK) begin
            if (byte_position == 16'd1) begin
              format_word_next = {8'd0, rx_byte};
            end else if (byte_position == 16'd2) begin
              format_word_next = {rx_byte, format_word[7:0]};
              if ({4'd0, need_bytes} > payload_length) begin
                frame_error_next = stlg_pkg::ST_OVERFLOW;
              end
            end else if (!byte_position[0] && (measure_index < format_word[9:0])) begin
              cmd_valid          = 1'b1;
              measure_index_next = measure_index + 10'd1;
            end
          end
          crc_accumulator_next = crc_fed;
          previous_byte_next   = rx_byte;
          byte_position_next   = byte_position + 16'd1;
        end
        stlg_pkg::PH_CRC_LO: begin
          previous_byte_next = rx_byte;
        end
        stlg_pkg::PH_CRC_HI: begin
          cmd_valid  = 1'b1;
          cmd.kind   = stlg_pkg::KIND_STATUS;
          cmd.index  = 10'd0;
          cmd.status = ({rx_byte, previous_byte} != crc_accumulator) ?
                       stlg_pkg::ST_CRC : frame_error;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= stlg_pkg::PH_HUNT;
      byte_position   <= 16'd0;
      payload_length  <= 16'd0;
      crc_accumulator <= 16'd0;
      previous_byte   <= 8'd0;
      format_word     <= 16'd0;
      measure_index   <= 10'd0;
      frame_error     <= stlg_pkg::ST_OK;
    end else begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      payload_length  <= payload_length_next;
      crc_accumulator <= crc_accumulator_next;
      previous_byte   <= previous_byte_next;
      format_word     <= format_word_next;
      measure_index   <= measure_index_next;
      frame_error     <= frame_error_next;
    end
  end

  a_cmd_needs_byte: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> in_valid)
    else $error("command issued without an accepted byte");

  a_status_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd.kind == stlg_pkg::KIND_STATUS) |=> phase == stlg_pkg::PH_HUNT)
    else $error("frame status not followed by hunting");

  a_index_moves_on_range: assert property (@(posedge clk) disable iff (rst)
    (in_valid && phase == stlg_pkg::PH_DATA && !cmd_valid) |=> $stable(measure_index))
    else $error("measurement index moved without a range");

endmodule

/* sv/stlg_cmd_queue.sv */
// ----------------------------------------------------------------------------
// stlg_cmd_queue
// Short command queue between parser and decoder.
// ----------------------------------------------------------------------------
module stlg_cmd_queue #(
  parameter int unsigned DEPTH = stlg_pkg::CMD_QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  stlg_pkg::cmd_t  wr_data,
  input  logic            rd_en,
  output stlg_pkg::cmd_t  rd_data,
  output logic            full,
  output logic            empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  stlg_pkg::cmd_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("write into full queue");

  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !empty)
    else $error("read from empty queue");

endmodule

/* sv/stlg_back.sv */
// ----------------------------------------------------------------------------
// stlg_back
// Range decoder with the registered result stage.
// ----------------------------------------------------------------------------
module stlg_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_ready_n,
  input  stlg_pkg::cmd_t      cmd,
  output logic                cmd_take,
  input  logic                pop,
  output logic                empty,
  output logic                item_kind,
  output logic signed [17:0]  range_value,
  output logic [9:0]          range_index,
  output logic [1:0]          frame_status,
  output logic [9:0]          range_count,
  output logic [1:0]          sub_scan_number,
  output logic                sub_scan_flag,
  output logic [1:0]          range_unit,
  output logic [16:0]         max_range_mm
);

  logic        out_valid;
  logic        cm_mode;
  logic [17:0] magnitude;
  logic        negative;
  logic [17:0] decoded;

  assign empty    = !out_valid;
  assign cmd_take = !cmd_ready_n && (!out_valid || pop);
  assign cm_mode  = (cmd.format[15:14] == stlg_pkg::UNIT_CM);

  // cm: 13-bit value times ten, mm: 15-bit value
  always_comb begin
    if (cm_mode) begin
      magnitude = {2'd0, cmd.word[12:0], 3'd0} + {4'd0, cmd.word[12:0], 1'b0};
      negative  = |cmd.word[15:13];
    end else begin
      magnitude = {3'd0, cmd.word[14:0]};
      negative  = cmd.word[15];
    end
    if (cmd.kind == stlg_pkg::KIND_STATUS) begin
      decoded = 18'd0;
    end else if (negative) begin
      decoded = 18'd0 - magnitude;
    end else begin
      decoded = magnitude;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      item_kind       <= cmd.kind;
      range_value     <= decoded;
      range_index     <= cmd.index;
      frame_status    <= cmd.status;
      range_count     <= cmd.format[9:0];
      sub_scan_number <= cmd.format[12:11];
      sub_scan_flag   <= cmd.format[13];
      range_unit      <= cmd.format[15:14];
      max_range_mm    <= cm_mode ? stlg_pkg::MAX_RANGE_CM : stlg_pkg::MAX_RANGE_MM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  a_take_refills: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> out_valid)
    else $error("taken command not presented");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && out_valid && !cmd_take) |=> !out_valid)
    else $error("result kept after transaction");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(item_kind) && $stable(range_value)))
    else $error("waiting result changed");

endmodule

/* sv/scan_telegram_receiver_unit.sv */
// ----------------------------------------------------------------------------
// scan_telegram_receiver_unit
// Serial scan telegram receiver: CRC check and range word decoding.
// ----------------------------------------------------------------------------
// Usage
//   Input side is a queue write port: present rx_byte with push; a transaction
//   completes on a clock edge with push high and full low. One byte per
//   transaction, one transaction per cycle sustained while full stays low.
//   Result side is a queue read port: while empty is low the oldest result is
//   on the result ports; pop high with empty low completes a transaction.
//   A range result passes from the parser through the command queue into the
//   decode register when that register is free; empty drops once it is loaded.
//   A frame ends with one status result (item_kind 1) whose frame_status gives
//   the verdict; ranges of a frame with non-zero status must be discarded by
//   the consumer.
//   Throughput is one byte per cycle while full stays low, set by the parser
//   step (CRC update and field capture) and the one-entry decode register.
//   If the consumer stops popping, results back up into the command queue
//   (QUEUE_DEPTH entries) and full rises; bytes are then held off.
//   Synchronous reset returns the parser to hunting for the start byte and
//   empties queue and result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module scan_telegram_receiver_unit #(
  parameter int unsigned MAX_FRAME_BYTES = stlg_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH     = stlg_pkg::CMD_QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          rx_byte,
  input  logic                pop,
  output logic                empty,
  output logic                item_kind,
  output logic signed [17:0]  range_value,
  output logic [9:0]          range_index,
  output logic [1:0]          frame_status,
  output logic [9:0]          range_count,
  output logic [1:0]          sub_scan_number,
  output logic                sub_scan_flag,
  output logic [1:0]          range_unit,
  output logic [16:0]         max_range_mm
);

  logic           in_accept;
  logic           cmd_valid;
  stlg_pkg::cmd_t cmd_wr;
  stlg_pkg::cmd_t cmd_head;
  logic           q_empty;
  logic           cmd_take;

  // byte taken only when the queue can absorb whatever it produces
  assign in_accept = push && !full;

  stlg_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_accept),
    .rx_byte   (rx_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_wr)
  );

  stlg_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd_wr),
    .rd_en   (cmd_take),
    .rd_data (cmd_head),
    .full    (full),
    .empty   (q_empty)
  );

  stlg_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_ready_n     (q_empty),
    .cmd             (cmd_head),
    .cmd_take        (cmd_take),
    .pop             (pop),
    .empty           (empty),
    .item_kind       (item_kind),
    .range_value     (range_value),
    .range_index     (range_index),
    .frame_status    (frame_status),
    .range_count     (range_count),
    .sub_scan_number (sub_scan_number),
    .sub_scan_flag   (sub_scan_flag),
    .range_unit      (range_unit),
    .max_range_mm    (max_range_mm)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scan telegram receiver testbench
// Feeds serial telegram bytes through the push/full side and pops decoded
// ranges and end-of-frame verdicts. A cycle-free parser model in the bench
// tracks every accepted byte and queues the result it should produce, and
// every popped transaction is checked field by field against it.
// ----------------------------------------------------------------------------
module testbench;

  // --------------------------------------------------------------------------
  // DUT connections; inputs start at known values
  // --------------------------------------------------------------------------
  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                push    = 1'b0;
  logic [7:0]          rx_byte = 8'h00;
  logic                pop     = 1'b0;
  logic                full;
  logic                empty;
  logic                item_kind;
  logic signed [17:0]  range_value;
  logic [9:0]          range_index;
  logic [1:0]          frame_status;
  logic [9:0]          range_count;
  logic [1:0]          sub_scan_number;
  logic                sub_scan_flag;
  logic [1:0]          range_unit;
  logic [16:0]         max_range_mm;

  scan_telegram_receiver_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .rx_byte         (rx_byte),
    .pop             (pop),
    .empty           (empty),
    .item_kind       (item_kind),
    .range_value     (range_value),
    .range_index     (range_index),
    .frame_status    (frame_status),
    .range_count     (range_count),
    .sub_scan_number (sub_scan_number),
    .sub_scan_flag   (sub_scan_flag),
    .range_unit      (range_unit),
    .max_range_mm    (max_range_mm)
  );

  // --------------------------------------------------------------------------
  // Types and bench storage
  // --------------------------------------------------------------------------
  typedef logic [7:0]  byte_q_t[$];
  typedef logic [15:0] word_q_t[$];

  // one decoded result as it should leave the block
  typedef struct packed {
    logic               kind;
    logic signed [17:0] value;
    logic [9:0]         index;
    logic [1:0]         status;
    logic [9:0]         count;
    logic [1:0]         sub_num;
    logic               sub_flag;
    logic [1:0]         unit;
    logic [16:0]        max_range;
  } scan_result_t;

  // a byte waiting to be offered; hold makes the sender wait for a drained block
  typedef struct {
    logic [7:0] data;
    bit         hold;
  } serial_byte_t;

  serial_byte_t serial_q[$];   // bytes not yet taken by the block
  scan_result_t scan_due[$];   // results owed by the block, oldest first

  int failures       = 0;
  int bytes_queued   = 0;
  int bytes_taken    = 0;
  int ranges_checked = 0;
  int status_tally[4] = '{0, 0, 0, 0};

  // --------------------------------------------------------------------------
  // Parser model state
  // --------------------------------------------------------------------------
  stlg_pkg::phase_t parse_phase = stlg_pkg::PH_HUNT;
  logic [15:0] data_pos    = '0;
  logic [15:0] data_len    = '0;
  logic [15:0] crc_run     = '0;
  logic [7:0]  last_byte   = '0;
  logic [15:0] fmt_word    = '0;
  logic [9:0]  next_index  = '0;
  logic [1:0]  verdict     = stlg_pkg::ST_OK;

  // scanner CRC: shift left, fold the polynomial in on carry out, then xor
  // in the previous and the new byte as one word
  function automatic logic [15:0] crc_advance(input logic [15:0] acc,
                                              input logic [7:0]  prev,
                                              input logic [7:0]  b);
    logic [15:0] sh;
    sh = {acc[14:0], 1'b0};
    if (acc[15]) begin
      sh = sh ^ stlg_pkg::CRC_POLY;
    end
    return sh ^ {prev, b};
  endfunction

  task automatic absorb(input logic [7:0] b);
    crc_run   = crc_advance(crc_run, last_byte, b);
    last_byte = b;
  endtask

  // cm mode: 13 bits times ten, any of the top three bits marks a reflector;
  // mm mode: 15 bits, top bit marks a reflector
  function automatic logic signed [17:0] range_decode(input logic [15:0] w);
    logic signed [17:0] mag;
    if (fmt_word[15:14] == stlg_pkg::UNIT_CM) begin
      mag = $signed({5'b0, w[12:0]}) * 18'sd10;
      if (w[15:13] != 3'b000) begin
        mag = -mag;
      end
    end else begin
      mag = $signed({3'b0, w[14:0]});
      if (w[15]) begin
        mag = -mag;
      end
    end
    return mag;
  endfunction

  // format fields ride on every result, zero until the format word is in
  function automatic scan_result_t make_result(input logic kind,
                                               input logic signed [17:0] value,
                                               input logic [9:0] index,
                                               input logic [1:0] status);
    scan_result_t r;
    r.kind      = kind;
    r.value     = value;
    r.index     = index;
    r.status    = status;
    r.count     = fmt_word[9:0];
    r.sub_num   = fmt_word[12:11];
    r.sub_flag  = fmt_word[13];
    r.unit      = fmt_word[15:14];
    r.max_range = (fmt_word[15:14] == stlg_pkg::UNIT_CM) ?
                  stlg_pkg::MAX_RANGE_CM : stlg_pkg::MAX_RANGE_MM;
    return r;
  endfunction

  // advance the parser model by one accepted byte and queue what it owes
  task automatic follow_telegram(input logic [7:0] b);
    int unsigned p;
    case (parse_phase)
      stlg_pkg::PH_HUNT: begin
        if (b == stlg_pkg::START_BYTE) begin
          crc_run     = '0;
          last_byte   = '0;
          fmt_word    = '0;
          next_index  = '0;
          verdict     = stlg_pkg::ST_OK;
          data_pos    = '0;
          data_len    = '0;
          absorb(b);
          parse_phase = stlg_pkg::PH_ADDR;
        end
      end
      stlg_pkg::PH_ADDR: begin
        absorb(b);
        parse_phase = stlg_pkg::PH_LEN_LO;
      end
      stlg_pkg::PH_LEN_LO: begin
        absorb(b);
        data_len    = {8'h00, b};
        parse_phase = stlg_pkg::PH_LEN_HI;
      end
      stlg_pkg::PH_LEN_HI: begin
        absorb(b);
        data_len[15:8] = b;
        if (32'(data_len) + 32'd6 > stlg_pkg::MAX_FRAME_BYTES_DEF) begin
          // oversize: verdict straight away, back to hunting
          scan_due.push_back(make_result(stlg_pkg::KIND_STATUS, '0, '0,
                                         stlg_pkg::ST_OVERFLOW));
          parse_phase = stlg_pkg::PH_HUNT;
        end else if (data_len == 16'd0) begin
          // no code byte at all
          verdict     = stlg_pkg::ST_CODE;
          parse_phase = stlg_pkg::PH_CRC_LO;
        end else begin
          data_pos    = '0;
          parse_phase = stlg_pkg::PH_DATA;
        end
      end
      stlg_pkg::PH_DATA: begin
        p = data_pos;
        if (p == 0) begin
          if (b != stlg_pkg::TELEGRAM_CODE) begin
            verdict = stlg_pkg::ST_CODE;
          end else if (data_len < 16'd3) begin
            verdict = stlg_pkg::ST_OVERFLOW;
          end
        end else if (verdict == stlg_pkg::ST_OK) begin
          if (p == 1) begin
            fmt_word = {8'h00, b};
          end else if (p == 2) begin
            fmt_word[15:8] = b;
            if (3 + 2 * int'(fmt_word[9:0]) > int'(data_len)) begin
              verdict = stlg_pkg::ST_OVERFLOW;
            end
          end else if ((p % 2) == 0 && next_index < fmt_word[9:0]) begin
            // high byte closes a range word; low byte is the one before
            scan_due.push_back(make_result(stlg_pkg::KIND_RANGE,
                                           range_decode({b, last_byte}),
                                           next_index, stlg_pkg::ST_OK));
            next_index = next_index + 10'd1;
          end
        end
        absorb(b);
        data_pos = data_pos + 16'd1;
        if (p + 1 >= int'(data_len)) begin
          parse_phase = stlg_pkg::PH_CRC_LO;
        end
      end
      stlg_pkg::PH_CRC_LO: begin
        last_byte   = b;
        parse_phase = stlg_pkg::PH_CRC_HI;
      end
      stlg_pkg::PH_CRC_HI: begin
        // a CRC mismatch outranks any other verdict
        scan_due.push_back(make_result(stlg_pkg::KIND_STATUS, '0, '0,
                           ({b, last_byte} != crc_run) ? stlg_pkg::ST_CRC : verdict));
        parse_phase = stlg_pkg::PH_HUNT;
      end
      default: begin
        parse_phase = stlg_pkg::PH_HUNT;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input bit hold);
    serial_byte_t s;
    s.data = b;
    s.hold = hold;
    serial_q.push_back(s);
    bytes_queued++;
  endtask

  // bytes seen while hunting; never the start byte
  task automatic add_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      do begin
        b = 8'($urandom);
      end while (b == stlg_pkg::START_BYTE);
      queue_byte(b, 1'b0);
    end
  endtask

  function automatic word_q_t random_words(input int n);
    word_q_t w;
    repeat (n) w.push_back(16'($urandom));
    return w;
  endfunction

  // code byte, little-endian format word, little-endian range words, tail
  function automatic byte_q_t scan_payload(input logic [7:0] code,
                                           input logic [15:0] fmt,
                                           input word_q_t words,
                                           input int tail);
    byte_q_t pl;
    pl.push_back(code);
    pl.push_back(fmt[7:0]);
    pl.push_back(fmt[15:8]);
    foreach (words[i]) begin
      pl.push_back(words[i][7:0]);
      pl.push_back(words[i][15:8]);
    end
    repeat (tail) pl.push_back(8'($urandom));
    return pl;
  endfunction

  // wrap a payload in head and CRC; corrupt spoils the CRC
  task automatic send_frame(input byte_q_t pl, input bit corrupt, input bit hold);
    byte_q_t     fr;
    logic [15:0] len;
    logic [15:0] acc;
    logic [7:0]  prev;
    len = 16'(pl.size());
    fr.push_back(stlg_pkg::START_BYTE);
    fr.push_back(8'($urandom));
    fr.push_back(len[7:0]);
    fr.push_back(len[15:8]);
    foreach (pl[i]) fr.push_back(pl[i]);
    acc  = '0;
    prev = '0;
    foreach (fr[i]) begin
      acc  = crc_advance(acc, prev, fr[i]);
      prev = fr[i];
    end
    if (corrupt) begin
      acc = acc ^ 16'($urandom_range(1, 16'hffff));
    end
    fr.push_back(acc[7:0]);
    fr.push_back(acc[15:8]);
    foreach (fr[i]) queue_byte(fr[i], hold && i == 0);
  endtask

  // head announcing more data than a frame may carry
  task automatic send_oversize(input logic [15:0] len);
    queue_byte(stlg_pkg::START_BYTE, 1'b0);
    queue_byte(8'($urandom), 1'b0);
    queue_byte(len[7:0], 1'b0);
    queue_byte(len[15:8], 1'b0);
  endtask

  // a stretch of the run in which neither side idles
  function automatic bit no_idle();
    return bytes_taken >= 400 && bytes_taken < 700;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  always #10 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sender: drives push and rx_byte on the falling edge. A held byte waits
  // until every owed result has been popped.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      push    <= 1'b0;
      rx_byte <= 8'h00;
    end else if (serial_q.size() == 0) begin
      push    <= 1'b0;
      rx_byte <= 8'($urandom);
    end else if (serial_q[0].hold && scan_due.size() != 0) begin
      push    <= 1'b0;
      rx_byte <= 8'($urandom);
    end else begin
      serial_q[0].hold = 1'b0;
      if (no_idle() || $urandom_range(99) >= 16) begin
        push    <= 1'b1;
        rx_byte <= serial_q[0].data;
      end else begin
        push    <= 1'b0;
        rx_byte <= 8'($urandom);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: drives pop on the falling edge. One long hold-off starts inside
  // the first long scan so the command queue backs up and full rises; short
  // random hold-offs come now and then.
  // --------------------------------------------------------------------------
  int stall_left      = 0;
  bit long_stall_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      pop <= 1'b0;
    end else if (!long_stall_done && !empty && item_kind == stlg_pkg::KIND_RANGE &&
                 range_index == 10'd8) begin
      long_stall_done = 1'b1;
      stall_left      = 299;
      pop <= 1'b0;
    end else if (!no_idle() && $urandom_range(1999) == 0) begin
      stall_left = $urandom_range(20, 100);
      pop <= 1'b0;
    end else begin
      pop <= no_idle() || ($urandom_range(99) >= 16);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: on the rising edge, an accepted byte advances the model and an
  // accepted result transaction is checked against the oldest owed result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    scan_result_t want;
    if (!rst) begin
      if (push && !full) begin
        follow_telegram(rx_byte);
        void'(serial_q.pop_front());
        bytes_taken++;
      end
      if (pop && !empty) begin
        if (scan_due.size() == 0) begin
          $display("%0t: unexpected result: kind %0d value %0d index %0d status %0d",
                   $time, item_kind, range_value, range_index, frame_status);
          failures++;
        end else begin
          want = scan_due.pop_front();
          check_field("item_kind", int'(want.kind), int'(item_kind));
          check_field("range_value", int'(want.value), int'(range_value));
          check_field("range_index", int'(want.index), int'(range_index));
          check_field("frame_status", int'(want.status), int'(frame_status));
          check_field("range_count", int'(want.count), int'(range_count));
          check_field("sub_scan_number", int'(want.sub_num), int'(sub_scan_number));
          check_field("sub_scan_flag", int'(want.sub_flag), int'(sub_scan_flag));
          check_field("range_unit", int'(want.unit), int'(range_unit));
          check_field("max_range_mm", int'(want.max_range), int'(max_range_mm));
          if (want.kind == stlg_pkg::KIND_RANGE) begin
            ranges_checked++;
          end else begin
            status_tally[int'(want.status)]++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed frames, then random traffic, then drain and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    word_q_t     w;
    byte_q_t     pl;
    byte_q_t     none;
    logic [15:0] fmt;
    logic [7:0]  code;
    int          pick;
    int          cnt;

    // hunting ignores everything but the start byte
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(stlg_pkg::TELEGRAM_CODE, 1'b0);
    queue_byte(8'h03, 1'b0);

    // cm mode: zero, largest value, reflector bits, negative zero
    w = {16'h0000, 16'h1fff, 16'h2001, 16'he000, 16'h9fff};
    send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, {2'd0, 1'b0, 2'd0, 1'b0, 10'd5}, w, 0),
               1'b0, 1'b0);
    // mm mode, sub scan 1
    w = {16'h7fff, 16'h8000, 16'h8001, 16'hffff};
    send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, {2'd1, 1'b0, 2'd1, 1'b0, 10'd4}, w, 0),
               1'b0, 1'b0);
    // unit 3 with every format flag, start byte inside data, trailing bytes
    w = {16'h1234, 16'h0202};
    send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, {2'd3, 1'b1, 2'd3, 1'b1, 10'd2}, w, 2),
               1'b0, 1'b0);
    w = {16'h5a5a};
    send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, {2'd2, 1'b0, 2'd2, 1'b0, 10'd1}, w, 0),
               1'b0, 1'b0);
    // no ranges announced
    w.delete();
    send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, 16'h0000, w, 1), 1'b0, 1'b0);
    // bad CRC over otherwise good ranges
    send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, {2'd0, 1'b0, 2'd0, 1'b0, 10'd3},
                            random_words(3), 0), 1'b1, 1'b0);
    // zero data length, good and bad CRC
    send_frame(none, 1'b0, 1'b0);
    send_frame(none, 1'b1, 1'b0);
    // wrong telegram codes
    send_frame(scan_payload(8'h00, 16'h0002, random_words(2), 0), 1'b0, 1'b0);
    pl = {8'hff};
    send_frame(pl, 1'b0, 1'b0);
    // right code but too short for the format word
    pl = {stlg_pkg::TELEGRAM_CODE};
    send_frame(pl, 1'b0, 1'b0);
    pl = {stlg_pkg::TELEGRAM_CODE, 8'h01};
    send_frame(pl, 1'b0, 1'b0);
    // count overflow, then the same with a bad CRC
    send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, 16'h03ff, random_words(2), 0),
               1'b0, 1'b0);
    send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, 16'hc3ff, random_words(2), 0),
               1'b1, 1'b0);
    // oversize heads
    send_oversize(16'(stlg_pkg::MAX_FRAME_BYTES_DEF - 5));
    add_noise(3);
    send_oversize(16'hffff);
    add_noise(2);
    // largest frame allowed, sent into an empty block
    send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, {2'd1, 1'b0, 2'd0, 1'b0, 10'd405},
                            random_words(405), 1), 1'b0, 1'b1);

    // random traffic: mostly well-formed frames with short scans
    while (bytes_queued < 1100) begin
      pick = $urandom_range(99);
      cnt  = $urandom_range(0, 12);
      fmt  = 16'($urandom);
      fmt[9:0] = 10'(cnt);
      if (pick < 70) begin
        send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, fmt, random_words(cnt),
                                $urandom_range(0, 3)), 1'b0, $urandom_range(39) == 0);
      end else if (pick < 78) begin
        send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, fmt, random_words(cnt),
                                $urandom_range(0, 3)), 1'b1, 1'b0);
      end else if (pick < 84) begin
        do begin
          code = 8'($urandom);
        end while (code == stlg_pkg::TELEGRAM_CODE);
        send_frame(scan_payload(code, fmt, random_words(cnt), $urandom_range(0, 2)),
                   $urandom_range(3) == 0, 1'b0);
      end else if (pick < 89) begin
        // more ranges announced than the data holds
        fmt[9:0] = 10'($urandom_range(cnt + 1, 1023));
        send_frame(scan_payload(stlg_pkg::TELEGRAM_CODE, fmt, random_words(cnt),
                                $urandom_range(0, 1)), $urandom_range(3) == 0, 1'b0);
      end else if (pick < 93) begin
        pl = scan_payload(stlg_pkg::TELEGRAM_CODE, fmt, random_words(0), 0);
        cnt = $urandom_range(0, 2);
        while (pl.size() > cnt) void'(pl.pop_back());
        send_frame(pl, $urandom_range(3) == 0, 1'b0);
      end else if (pick < 96) begin
        send_oversize(16'($urandom_range(stlg_pkg::MAX_FRAME_BYTES_DEF - 5, 16'hffff)));
      end else begin
        add_noise($urandom_range(1, 8));
      end
      add_noise($urandom_range(0, 2));
    end

    // let every byte go in and every owed result come out
    while (serial_q.size() != 0 || scan_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d telegram bytes: %0d ranges checked, %0d frame verdicts",
             bytes_taken, ranges_checked,
             status_tally[0] + status_tally[1] + status_tally[2] + status_tally[3]);
    $display("Verdicts: ok %0d, crc %0d, code %0d, overflow %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (failures == 0) begin
      $display("** scan_telegram_receiver_unit: PASSED **");
    end else begin
      $display("** scan_telegram_receiver_unit: FAILED **");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("Timeout: %0d bytes still queued, %0d results still owed",
             serial_q.size(), scan_due.size());
    $display("** scan_telegram_receiver_unit: FAILED **");
    $finish;
  end

endmodule
